// ===== hw/rtl/csir_pkg.sv =====
// Shared types, register addresses and codes for the card slot interrupt block.
package csir_pkg;

  // Item action codes
  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_LINE    = 2'd2;
  localparam logic [1:0] ACT_RECHECK = 2'd3;

  // Disk port layouts
  localparam logic [1:0] DISK_NONE = 2'd0;
  localparam logic [1:0] DISK_LOW  = 2'd1;
  localparam logic [1:0] DISK_HIGH = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DISK_MODE = 1'b0;
  localparam logic CFG_PRESENT   = 1'b1;

  // Register addresses (low 16 bits)
  localparam logic [15:0] ADDR_STATUS   = 16'h8000;
  localparam logic [15:0] ADDR_CHANGE   = 16'h9000;
  localparam logic [15:0] ADDR_ENABLE   = 16'hA000;
  localparam logic [15:0] ADDR_TIMING   = 16'hB000;
  localparam logic [15:0] ADDR_RTC_LO   = 16'h3020;
  localparam logic [15:0] ADDR_RTC_HI   = 16'h3021;
  localparam logic [15:0] ADDR_ID       = 16'h201C;
  localparam logic [15:0] ADDR_HI_WIN   = 16'h4000;

  // Card line bits in the status and change bytes
  localparam logic [7:0] BIT_DISK   = 8'h80;
  localparam logic [7:0] BIT_DETECT = 8'h40;
  localparam logic [7:0] BIT_BAT1   = 8'h20;
  localparam logic [7:0] BIT_BAT2   = 8'h10;
  localparam logic [7:0] BIT_WP     = 8'h08;
  localparam logic [7:0] BIT_BUSY   = 8'h04;
  localparam logic [7:0] CARD_LINES = 8'h7C;
  localparam logic [7:0] MASK_HI6   = 8'hFC;

  typedef struct packed {
    logic [7:0] change;
    logic [7:0] enable;
    logic [7:0] lines;
    logic [7:0] mask;
    logic [7:0] timing;
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] address;
    logic [7:0]  write_data;
    logic [2:0]  line_select;
    logic        line_level;
    logic        disk_irq;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       passes_to_disk;
    logic       level2_request;
    logic       level6_request;
    logic       reset_request;
    logic       bus_error_request;
  } result_t;

  // Line select to status bit; unused codes give no bit
  function automatic logic [7:0] line_bit(input logic [2:0] sel);
    logic [7:0] b;
    case (sel)
      3'd0:    b = BIT_DETECT;
      3'd1:    b = BIT_BAT1;
      3'd2:    b = BIT_BAT2;
      3'd3:    b = BIT_WP;
      3'd4:    b = BIT_BUSY;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/csir_step.sv =====
// Single-beat combinational update: register decode, line events and interrupt mapping.
module csir_step (
  input  csir_pkg::state_t  cur,
  input  csir_pkg::item_t   item,
  input  logic [1:0]        disk_mode,
  input  logic              card_slot_present,
  output csir_pkg::state_t  nxt,
  output csir_pkg::result_t res
);

  logic [15:0] a;
  logic        addr_ok;
  logic        active;
  logic [7:0]  lbit;
  logic [7:0]  m;
  logic [7:0]  old_lines;
  logic [7:0]  clr;
  logic        done;
  logic [7:0]  st_change;

  always_comb begin
    nxt = cur;
    res = '0;
    a = item.address[15:0];
    addr_ok = !((disk_mode == csir_pkg::DISK_LOW) && !(item.address[19] && item.address[17]));
    active = (disk_mode == csir_pkg::DISK_LOW) || (disk_mode == csir_pkg::DISK_HIGH) ||
             card_slot_present;
    lbit = csir_pkg::line_bit(item.line_select);
    m = '0;
    old_lines = cur.lines;
    clr = '0;
    done = 1'b0;
    st_change = '0;

    case (item.action)
      // Bus read
      csir_pkg::ACT_READ: begin
        if (!addr_ok) begin
          res.read_data = '0;
        end else if (card_slot_present && disk_mode != csir_pkg::DISK_LOW &&
                     a == csir_pkg::ADDR_CHANGE) begin
          res.read_data = cur.change;
        end else if (card_slot_present && disk_mode != csir_pkg::DISK_LOW &&
                     a == csir_pkg::ADDR_ENABLE) begin
          res.read_data = cur.enable;
        end else if (card_slot_present && a == csir_pkg::ADDR_STATUS) begin
          res.read_data = cur.mask | cur.lines | (item.disk_irq ? csir_pkg::BIT_DISK : 8'h00);
        end else if (card_slot_present && a == csir_pkg::ADDR_TIMING) begin
          res.read_data = {4'h0, cur.timing[3:0]};
        end else if (disk_mode == csir_pkg::DISK_NONE) begin
          res.read_data = (a == csir_pkg::ADDR_ID) ? 8'h7F : 8'hFF;
        end else if (disk_mode == csir_pkg::DISK_HIGH &&
                     (a == csir_pkg::ADDR_RTC_LO || a == csir_pkg::ADDR_RTC_HI)) begin
          // read to clear
          res.read_data = cur.change;
          nxt.change = '0;
        end else if (a >= csir_pkg::ADDR_HI_WIN) begin
          if (disk_mode == csir_pkg::DISK_LOW && a == csir_pkg::ADDR_CHANGE)
            res.read_data = cur.change;
          else if (disk_mode == csir_pkg::DISK_LOW && a == csir_pkg::ADDR_ENABLE)
            res.read_data = cur.enable;
          else
            res.read_data = '0;
        end else begin
          res.passes_to_disk = 1'b1;
        end
      end

      // Bus write
      csir_pkg::ACT_WRITE: begin
        if (addr_ok) begin
          if (card_slot_present) begin
            if (disk_mode != csir_pkg::DISK_LOW && a == csir_pkg::ADDR_CHANGE) begin
              nxt.change = (cur.change & item.write_data) | {6'h00, item.write_data[1:0]};
              done = 1'b1;
            end else if (disk_mode != csir_pkg::DISK_LOW && a == csir_pkg::ADDR_ENABLE) begin
              nxt.enable = item.write_data;
              done = 1'b1;
            end else if (a == csir_pkg::ADDR_STATUS) begin
              nxt.mask = item.write_data & csir_pkg::MASK_HI6;
              nxt.lines = (old_lines & csir_pkg::MASK_HI6) | {6'h00, item.write_data[1:0]};
              // slot disable: card lines forced low, detect first
              if (!old_lines[0] && item.write_data[0]) begin
                nxt.timing = '0;
                clr = nxt.lines & csir_pkg::CARD_LINES;
                nxt.lines = nxt.lines & ~csir_pkg::CARD_LINES;
                nxt.change = cur.change | clr;
                if ((clr & csir_pkg::BIT_DETECT) != 8'h00 && cur.change[1:0] != 2'b11) begin
                  res.reset_request = cur.change[1];
                  res.bus_error_request = cur.change[0];
                end
              end
              done = 1'b1;
            end else if (a == csir_pkg::ADDR_TIMING) begin
              nxt.timing = item.write_data;
              done = 1'b1;
            end
          end
          if (!done && disk_mode != csir_pkg::DISK_NONE) begin
            if (disk_mode == csir_pkg::DISK_LOW && a == csir_pkg::ADDR_CHANGE) begin
              nxt.change = (cur.change & item.write_data) | {6'h00, item.write_data[1:0]};
            end else if (disk_mode == csir_pkg::DISK_LOW && a == csir_pkg::ADDR_ENABLE) begin
              nxt.enable = item.write_data;
            end else if (a < csir_pkg::ADDR_HI_WIN) begin
              res.passes_to_disk = 1'b1;
            end
          end
        end
      end

      // Card line event
      csir_pkg::ACT_LINE: begin
        if (lbit != 8'h00 && ((cur.lines & lbit) != 8'h00) != item.line_level) begin
          nxt.lines = item.line_level ? (cur.lines | lbit) : (cur.lines & ~lbit);
          st_change = cur.change | lbit;
          nxt.change = st_change;
          if (lbit == csir_pkg::BIT_DETECT && st_change[1:0] != 2'b11) begin
            res.reset_request = st_change[1];
            res.bus_error_request = st_change[0];
          end
        end
      end

      default: begin
      end
    endcase

    // Interrupt recheck on the updated change byte
    if (active && item.disk_irq)
      nxt.change = nxt.change | csir_pkg::BIT_DISK;
    if (disk_mode == csir_pkg::DISK_HIGH) begin
      res.level2_request = nxt.change[7];
    end else if (active) begin
      m = nxt.enable & nxt.change;
      res.level2_request = m[7] || m[3] ||
                           ((m[5] || m[4]) && !nxt.enable[1]) ||
                           (m[2] && !nxt.enable[0]);
      res.level6_request = m[6] ||
                           ((m[5] || m[4]) && nxt.enable[1]) ||
                           (m[2] && nxt.enable[0]);
    end
  end

endmodule

// ===== hw/rtl/card_slot_interrupt_registers_core.sv =====
// Top level: input register, register state, step logic and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | to block  | in_valid / in_stall  | action address write_data line_select ...
//  out     | from blk  | out_valid / out_stall| read_data passes_to_disk level2/6 reset berr
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index cfg_data
//
// An input beat is registered in the input register, then evaluated and written to the result
// register; one beat per cycle is sustained while out_stall is low, set by the single
// update of the byte registers. Reset (rst, synchronous) clears all byte registers,
// sets disk_mode to the low-end layout and the card slot off. A stalled output holds the
// result register; the input register then fills and in_stall rises.
module card_slot_interrupt_registers_core (
  input  logic        clk,
  input  logic        rst,
  // input beat
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [23:0] address,
  input  logic [7:0]  write_data,
  input  logic [2:0]  line_select,
  input  logic        line_level,
  input  logic        disk_irq,
  // result beat
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        passes_to_disk,
  output logic        level2_request,
  output logic        level6_request,
  output logic        reset_request,
  output logic        bus_error_request,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  logic               s1_valid;
  csir_pkg::item_t    s1_item;
  csir_pkg::state_t   state;
  csir_pkg::state_t   state_next;
  csir_pkg::result_t  res_next;
  csir_pkg::result_t  res;
  logic [1:0]         disk_mode;
  logic               card_slot_present;
  logic               out_free;
  logic               s1_fire;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= '{action: action, address: address, write_data: write_data,
                   line_select: line_select, line_level: line_level, disk_irq: disk_irq};
    end
  end

  // Step logic
  csir_step u_step (
    .cur               (state),
    .item              (s1_item),
    .disk_mode         (disk_mode),
    .card_slot_present (card_slot_present),
    .nxt               (state_next),
    .res               (res_next)
  );

  // Byte registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_mode         <= csir_pkg::DISK_LOW;
      card_slot_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == csir_pkg::CFG_DISK_MODE)
        disk_mode <= cfg_data;
      else
        card_slot_present <= cfg_data[0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= res_next;
    end
  end

  assign read_data         = res.read_data;
  assign passes_to_disk    = res.passes_to_disk;
  assign level2_request    = res.level2_request;
  assign level6_request    = res.level6_request;
  assign reset_request     = res.reset_request;
  assign bus_error_request = res.bus_error_request;

endmodule

// ===== tb/csir_tracker_pkg.sv =====
// Expected-result tracker for the card slot interrupt block: state mirror and result checks.
package csir_tracker_pkg;
  import csir_pkg::*;

  // Disk port with neither layout's registers
  localparam logic [1:0] DISK_BARE = 2'd3;

  // Status bit of each card line, by line select
  localparam int NUM_LINES = 5;
  localparam logic [7:0] LINE_BITS [NUM_LINES] = '{BIT_DETECT, BIT_BAT1, BIT_BAT2, BIT_WP,
                                                   BIT_BUSY};

  class slot_irq_tracker;
    logic [1:0] disk_mode;
    bit         slot_on;
    logic [7:0] change;
    logic [7:0] enable;
    logic [7:0] lines;
    logic [7:0] mask;
    logic [7:0] timing;
    bit         want_reset;
    bit         want_berr;
    result_t    awaited[$];
    int         errors;

    function new();
      disk_mode = DISK_LOW;
      slot_on   = 1'b0;
      change    = '0;
      enable    = '0;
      lines     = '0;
      mask      = '0;
      timing    = '0;
      errors    = 0;
    endfunction

    function void set_config(logic idx, logic [1:0] val);
      if (idx == CFG_DISK_MODE) begin
        disk_mode = val;
      end else begin
        slot_on = val[0];
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Card line moves: latch change, detect edge may ask for reset or bus error
    function void move_line(logic [7:0] b, bit lvl);
      if (((lines & b) != 0) == lvl) return;
      if (lvl) lines = lines | b;
      else lines = lines & ~b;
      change = change | b;
      if ((b & BIT_DETECT) != 0 && change[1:0] != 2'b11) begin
        if (change[1]) want_reset = 1'b1;
        if (change[0]) want_berr = 1'b1;
      end
    endfunction

    // Status write; rising slot-off bit drops every card line
    function void write_status(logic [7:0] v);
      logic was_off;
      was_off = lines[0];
      mask = v & MASK_HI6;
      lines = {lines[7:2], v[1:0]};
      if (!was_off && lines[0]) begin
        timing = '0;
        move_line(BIT_DETECT, 1'b0);
        move_line(BIT_BAT2, 1'b0);
        move_line(BIT_BAT1, 1'b0);
        move_line(BIT_WP, 1'b0);
        move_line(BIT_BUSY, 1'b0);
      end
    endfunction

    // Change register write: zeros clear, low two bits set directly
    function void ack_changes(logic [7:0] v);
      change = (change & v) | (v & 8'h03);
    endfunction

    function logic [7:0] bus_read(logic [23:0] addr, bit dirq, output bit todisk);
      logic [15:0] a;
      logic [7:0]  snap;
      todisk = 1'b0;
      a = addr[15:0];
      if (disk_mode == DISK_LOW && !(addr[19] && addr[17])) return 8'h00;
      if (slot_on) begin
        if (disk_mode != DISK_LOW) begin
          if (a == ADDR_CHANGE) return change;
          if (a == ADDR_ENABLE) return enable;
        end
        if (a == ADDR_STATUS) return mask | lines | (dirq ? BIT_DISK : 8'h00);
        if (a == ADDR_TIMING) return timing & 8'h0F;
      end
      if (disk_mode == DISK_NONE) return (a == ADDR_ID) ? 8'h7F : 8'hFF;
      // read-to-clear change register of the high-end layout
      if (disk_mode == DISK_HIGH && (a == ADDR_RTC_LO || a == ADDR_RTC_HI)) begin
        snap = change;
        change = '0;
        return snap;
      end
      if (a >= ADDR_HI_WIN) begin
        if (disk_mode == DISK_LOW && a == ADDR_CHANGE) return change;
        if (disk_mode == DISK_LOW && a == ADDR_ENABLE) return enable;
        return 8'h00;
      end
      todisk = 1'b1;
      return 8'h00;
    endfunction

    function void bus_write(logic [23:0] addr, logic [7:0] v, output bit todisk);
      logic [15:0] a;
      todisk = 1'b0;
      a = addr[15:0];
      if (disk_mode == DISK_LOW && !(addr[19] && addr[17])) return;
      if (slot_on) begin
        if (disk_mode != DISK_LOW) begin
          if (a == ADDR_CHANGE) begin
            ack_changes(v);
            return;
          end
          if (a == ADDR_ENABLE) begin
            enable = v;
            return;
          end
        end
        if (a == ADDR_STATUS) begin
          write_status(v);
          return;
        end
        if (a == ADDR_TIMING) begin
          timing = v;
          return;
        end
      end
      if (disk_mode == DISK_NONE) return;
      if (disk_mode == DISK_LOW) begin
        if (a == ADDR_CHANGE) begin
          ack_changes(v);
          return;
        end
        if (a == ADDR_ENABLE) begin
          enable = v;
          return;
        end
      end
      if (a >= ADDR_HI_WIN) return;
      todisk = 1'b1;
    endfunction

    // Interrupt outputs after every beat
    function void recheck(bit dirq, output bit l2, output bit l6);
      logic [7:0] m;
      l2 = 1'b0;
      l6 = 1'b0;
      if (disk_mode == DISK_HIGH) begin
        if (dirq) change = change | BIT_DISK;
        l2 = change[7];
        return;
      end
      if (disk_mode != DISK_LOW && !slot_on) return;
      if (dirq) change = change | BIT_DISK;
      m = enable & change;
      if ((m & (BIT_DISK | BIT_WP)) != 0) l2 = 1'b1;
      if ((m & BIT_DETECT) != 0) l6 = 1'b1;
      if ((m & (BIT_BAT1 | BIT_BAT2)) != 0) begin
        if (enable[1]) l6 = 1'b1;
        else l2 = 1'b1;
      end
      if ((m & BIT_BUSY) != 0) begin
        if (enable[0]) l6 = 1'b1;
        else l2 = 1'b1;
      end
    endfunction

    // Accepted input beat: update the mirror and queue the expected result
    function void note_beat(item_t it);
      result_t r;
      bit      todisk;
      bit      l2;
      bit      l6;
      r = '0;
      todisk = 1'b0;
      want_reset = 1'b0;
      want_berr = 1'b0;
      case (it.action)
        ACT_READ: begin
          r.read_data = bus_read(it.address, it.disk_irq, todisk);
        end
        ACT_WRITE: begin
          bus_write(it.address, it.write_data, todisk);
        end
        ACT_LINE: begin
          if (it.line_select < NUM_LINES) move_line(LINE_BITS[it.line_select], it.line_level);
        end
        default: ;
      endcase
      recheck(it.disk_irq, l2, l6);
      r.passes_to_disk    = todisk;
      r.level2_request    = l2;
      r.level6_request    = l6;
      r.reset_request     = want_reset;
      r.bus_error_request = want_berr;
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Accepted result beat against the oldest expectation
    task check_beat(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = awaited.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
      if (got.passes_to_disk !== want.passes_to_disk)
        report($sformatf("passes_to_disk %b, expected %b",
                         got.passes_to_disk, want.passes_to_disk));
      if (got.level2_request !== want.level2_request)
        report($sformatf("level2_request %b, expected %b",
                         got.level2_request, want.level2_request));
      if (got.level6_request !== want.level6_request)
        report($sformatf("level6_request %b, expected %b",
                         got.level6_request, want.level6_request));
      if (got.reset_request !== want.reset_request)
        report($sformatf("reset_request %b, expected %b",
                         got.reset_request, want.reset_request));
      if (got.bus_error_request !== want.bus_error_request)
        report($sformatf("bus_error_request %b, expected %b",
                         got.bus_error_request, want.bus_error_request));
    endtask
  endclass

endpackage

// ===== tb/card_slot_interrupt_registers_core_test.sv =====
// Top-level testbench: drives bus beats, line events and config writes, checks every result.
module card_slot_interrupt_registers_core_test;
  import csir_pkg::*;
  import csir_tracker_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE       = 4;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 82;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_READ;
  logic [23:0] address = '0;
  logic [7:0]  write_data = '0;
  logic [2:0]  line_select = '0;
  logic        line_level = 1'b0;
  logic        disk_irq = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        passes_to_disk;
  logic        level2_request;
  logic        level6_request;
  logic        reset_request;
  logic        bus_error_request;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_DISK_MODE;
  logic [1:0]  cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  slot_irq_tracker tracker;

  card_slot_interrupt_registers_core dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Input beats into the tracker
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      tracker.note_beat(item_t'{action, address, write_data, line_select, line_level,
                                disk_irq});
  end

  // Result beats checked; receiver stalls at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_beat(result_t'{read_data, passes_to_disk, level2_request,
                                   level6_request, reset_request, bus_error_request});
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: too long without any beat moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic item_t mk(logic [1:0] act, logic [23:0] addr, logic [7:0] data = '0,
                               logic [2:0] sel = '0, logic lvl = 1'b0, logic dirq = 1'b0);
    return item_t'{act, addr, data, sel, lvl, dirq};
  endfunction

  // Mostly decoded register addresses, some disk window and fully random ones
  function automatic item_t random_access();
    item_t       it;
    logic [15:0] lo;
    logic [7:0]  hi;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 30) it.action = ACT_READ;
    else if (pick < 65) it.action = ACT_WRITE;
    else if (pick < 90) it.action = ACT_LINE;
    else it.action = ACT_RECHECK;
    case ($urandom_range(11))
      0, 1:    lo = ADDR_STATUS;
      2:       lo = ADDR_CHANGE;
      3:       lo = ADDR_ENABLE;
      4:       lo = ADDR_TIMING;
      5:       lo = ADDR_RTC_LO;
      6:       lo = ADDR_RTC_HI;
      7:       lo = ADDR_ID;
      8, 9:    lo = 16'($urandom_range(ADDR_HI_WIN - 1));
      default: lo = 16'($urandom);
    endcase
    hi = 8'($urandom);
    // low-end layout decodes only with address bits 19 and 17 set
    if ($urandom_range(3) != 0) begin
      hi[3] = 1'b1;
      hi[1] = 1'b1;
    end
    it.address = {hi, lo};
    it.write_data = 8'($urandom);
    if ($urandom_range(9) == 0) it.line_select = 3'($urandom_range(7, NUM_LINES));
    else it.line_select = 3'($urandom_range(NUM_LINES - 1));
    it.line_level = 1'($urandom);
    it.disk_irq = ($urandom_range(3) == 0);
    return it;
  endfunction

  task automatic send_beat(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= it.action;
    address     <= it.address;
    write_data  <= it.write_data;
    line_select <= it.line_select;
    line_level  <= it.line_level;
    disk_irq    <= it.disk_irq;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender until every expected result is back, then let the pipe empty
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] mode, logic present);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DISK_MODE;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_config(CFG_DISK_MODE, mode);
    cfg_index <= CFG_PRESENT;
    cfg_data  <= {1'b0, present};
    do @(posedge clk); while (!cfg_ready);
    tracker.set_config(CFG_PRESENT, {1'b0, present});
    cfg_valid <= 1'b0;
  endtask

  task automatic directed();
    // reset layout: low-end, no card slot
    send_beat(mk(ACT_READ, 24'h0A9000));
    send_beat(mk(ACT_WRITE, 24'h0AA000, 8'h8C));
    send_beat(mk(ACT_READ, 24'h0AA000));
    send_beat(mk(ACT_READ, 24'h009000));
    send_beat(mk(ACT_READ, 24'hFFFFFF));
    send_beat(mk(ACT_READ, 24'h0A0100));
    send_beat(mk(ACT_RECHECK, 24'h000000, 8'h00, 3'd0, 1'b0, 1'b1));
    wait_results();
    // no disk port, card slot on: detect requests and slot disable
    write_config(DISK_NONE, 1'b1);
    send_beat(mk(ACT_WRITE, {8'h00, ADDR_CHANGE}, 8'h02));
    send_beat(mk(ACT_LINE, 24'h000000, 8'h00, 3'd0, 1'b1));
    send_beat(mk(ACT_WRITE, {8'h00, ADDR_CHANGE}, 8'h01));
    send_beat(mk(ACT_WRITE, {8'h00, ADDR_STATUS}, 8'h01));
    send_beat(mk(ACT_READ, {8'h00, ADDR_STATUS}, 8'h00, 3'd0, 1'b0, 1'b1));
    send_beat(mk(ACT_READ, {8'h00, ADDR_ID}));
    send_beat(mk(ACT_READ, 24'h001234));
    send_beat(mk(ACT_WRITE, {8'h00, ADDR_ENABLE}, 8'hFF));
    send_beat(mk(ACT_WRITE, {8'h00, ADDR_TIMING}, 8'hFF));
    send_beat(mk(ACT_READ, {8'h00, ADDR_TIMING}));
    send_beat(mk(ACT_LINE, 24'h000000, 8'h00, 3'd7, 1'b1));
    send_beat(mk(ACT_LINE, 24'h000000, 8'h00, 3'd4, 1'b1));
    wait_results();
    // high-end layout: read-to-clear, undecoded high window, disk window
    write_config(DISK_HIGH, 1'b0);
    send_beat(mk(ACT_RECHECK, 24'h000000, 8'h00, 3'd0, 1'b0, 1'b1));
    send_beat(mk(ACT_READ, {8'h00, ADDR_RTC_LO}));
    send_beat(mk(ACT_READ, {8'hFF, ADDR_RTC_HI}));
    send_beat(mk(ACT_READ, 24'h005000));
    send_beat(mk(ACT_READ, 24'h000100));
    send_beat(mk(ACT_WRITE, 24'h000200, 8'h55));
    send_beat(mk(ACT_WRITE, 24'h006000, 8'hAA));
  endtask

  initial begin
    logic [1:0] mode;
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results();
      mode = 2'(ph % 4);
      write_config(mode, ph >= PHASES / 2);
      case ((ph + ph / 4) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mid-phase pause until the pipe is empty
        if (ph % 2 == 1 && n == PHASE_ITEMS / 2) wait_results();
        send_beat(random_access());
      end
    end
    wait_results();
    if (tracker.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
